/* hdl/i2c_master_phase_sequencer_macros.svh */
//------------------------------------------------------------------------------
// I2C master phase sequencer assertion macros
// Shared concurrent assertion forms for the sequencer modules.
//------------------------------------------------------------------------------
`ifndef I2C_MASTER_PHASE_SEQUENCER_MACROS_SVH
`define I2C_MASTER_PHASE_SEQUENCER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define I2CPS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define I2CPS_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* hdl/i2cps_pkg.sv */
//------------------------------------------------------------------------------
// I2C master phase sequencer package
// Command codes, queue entry type and phase count constants.
//------------------------------------------------------------------------------
package i2cps_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int OP_W          = 3;
   localparam int PHASE_W       = 5;

   localparam logic [OP_W-1:0] OP_START  = 3'd0;
   localparam logic [OP_W-1:0] OP_STOP   = 3'd1;
   localparam logic [OP_W-1:0] OP_CLKACK = 3'd2;
   localparam logic [OP_W-1:0] OP_ACK    = 3'd3;
   localparam logic [OP_W-1:0] OP_NACK   = 3'd4;
   localparam logic [OP_W-1:0] OP_WRITE  = 3'd5;
   localparam logic [OP_W-1:0] OP_READ   = 3'd6;

   localparam logic [PHASE_W-1:0] LAST_START  = PHASE_W'(3);
   localparam logic [PHASE_W-1:0] LAST_STOP   = PHASE_W'(3);
   localparam logic [PHASE_W-1:0] LAST_CLKACK = PHASE_W'(1);
   localparam logic [PHASE_W-1:0] LAST_ACK    = PHASE_W'(2);
   localparam logic [PHASE_W-1:0] LAST_WRITE  = PHASE_W'(3 * BITS_PER_BYTE);
   localparam logic [PHASE_W-1:0] LAST_READ   = PHASE_W'(2 * BITS_PER_BYTE + 1);

   typedef enum logic [2:0] {
      CMD_START,
      CMD_STOP,
      CMD_CLKACK,
      CMD_ACK,
      CMD_NACK,
      CMD_WRITE,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type               kind;
      logic [PHASE_W-1:0]         last_phase;
      logic [BITS_PER_BYTE-1:0]   data;
   } cmd_type;

endpackage

/* hdl/i2cps_front.sv */
//------------------------------------------------------------------------------
// I2C master phase sequencer front end
// Accepts command transfers, decodes the opcode and drops unused codes.
//------------------------------------------------------------------------------
module i2cps_front (
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [15:0]                  req_tdata,   // tx_byte, line_bits
   input  logic [2:0]                   req_tuser,   // op
   input  logic                         queue_full,
   output logic                         push_valid,
   output i2cps_pkg::cmd_type           push_entry
);
   import i2cps_pkg::*;

   logic known;

   always_comb begin
      known                 = 1'b1;
      push_entry.data       = req_tdata[7:0];
      push_entry.kind       = CMD_START;
      push_entry.last_phase = LAST_START;
      unique case (req_tuser)
         OP_START: begin
            push_entry.kind       = CMD_START;
            push_entry.last_phase = LAST_START;
         end
         OP_STOP: begin
            push_entry.kind       = CMD_STOP;
            push_entry.last_phase = LAST_STOP;
         end
         OP_CLKACK: begin
            push_entry.kind       = CMD_CLKACK;
            push_entry.last_phase = LAST_CLKACK;
         end
         OP_ACK: begin
            push_entry.kind       = CMD_ACK;
            push_entry.last_phase = LAST_ACK;
         end
         OP_NACK: begin
            push_entry.kind       = CMD_NACK;
            push_entry.last_phase = LAST_ACK;
         end
         OP_WRITE: begin
            push_entry.kind       = CMD_WRITE;
            push_entry.last_phase = LAST_WRITE;
         end
         OP_READ: begin
            push_entry.kind       = CMD_READ;
            push_entry.last_phase = LAST_READ;
            push_entry.data       = req_tdata[15:8];
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   assign req_tready = !queue_full && !reset;
   assign push_valid = req_tvalid && req_tready && known;

endmodule

/* hdl/i2cps_queue.sv */
//------------------------------------------------------------------------------
// I2C master phase sequencer command queue
// Short FIFO of decoded commands between front end and sequencer.
//------------------------------------------------------------------------------
module i2cps_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  i2cps_pkg::cmd_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output i2cps_pkg::cmd_type  head_entry
);
   import i2cps_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign full       = count_ff == CNT_FULL;
   assign head_valid = count_ff != '0;
   assign head_entry = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hdl/i2cps_back.sv */
//------------------------------------------------------------------------------
// I2C master phase sequencer back end
// Steps the head command through its pin phases, one result per cycle unless stalled.
//------------------------------------------------------------------------------
`include "i2c_master_phase_sequencer_macros.svh"

module i2cps_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  i2cps_pkg::cmd_type  head_entry,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,   // scl_level, sda_level, rx_byte
   output logic                rsp_tuser,   // sample_point
   output logic                rsp_tlast
);
   import i2cps_pkg::*;

   localparam int MSB = BITS_PER_BYTE - 1;
   localparam logic [1:0] SUB_LAST = 2'd2;

   logic [PHASE_W-1:0]       phase_ff, phase_in;
   logic [1:0]               sub_ff, sub_in;
   logic                     scl_ff, scl_in;
   logic                     sda_ff, sda_in;
   logic [BITS_PER_BYTE-1:0] shift_ff, shift_in;
   logic [BITS_PER_BYTE-1:0] rx_ff, rx_in;
   logic                     rsp_valid_ff;
   logic                     out_scl_ff, out_sda_ff, out_sample_ff, out_last_ff;
   logic [BITS_PER_BYTE-1:0] out_rx_ff;
   logic                     sample_in, last_in;
   logic [BITS_PER_BYTE-1:0] out_rx_in;
   logic                     first, advance;

   assign first   = phase_ff == '0;
   assign advance = head_valid && (!rsp_valid_ff || rsp_tready);
   assign last_in = phase_ff == head_entry.last_phase;
   assign pop     = advance && last_in;

   always_comb begin
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      sample_in = 1'b0;
      out_rx_in = '0;
      rx_in     = rx_ff;
      shift_in  = first ? head_entry.data : shift_ff;
      sub_in    = sub_ff;
      unique case (head_entry.kind)
         CMD_START: begin
            priority if (phase_ff == PHASE_W'(0)) sda_in = 1'b1;
            else if (phase_ff == PHASE_W'(1))     scl_in = 1'b1;
            else if (phase_ff == PHASE_W'(2))     sda_in = 1'b0;
            else                                  scl_in = 1'b0;
         end
         CMD_STOP: begin
            priority if (phase_ff == PHASE_W'(0)) scl_in = 1'b1;
            else if (phase_ff == PHASE_W'(1))     sda_in = 1'b0;
            else if (phase_ff == PHASE_W'(2))     sda_in = 1'b1;
            else                                  scl_in = 1'b0;
         end
         CMD_CLKACK: begin
            scl_in = first;
         end
         CMD_ACK, CMD_NACK: begin
            priority if (first)                   sda_in = head_entry.kind == CMD_NACK;
            else if (phase_ff == PHASE_W'(1))     scl_in = 1'b1;
            else                                  scl_in = 1'b0;
         end
         CMD_WRITE: begin
            sub_in = (sub_ff == SUB_LAST) ? 2'd0 : sub_ff + 2'd1;
            priority if (phase_ff == LAST_WRITE) begin
               sda_in = 1'b0;
            end else if (sub_ff == 2'd0) begin
               sda_in = first ? head_entry.data[MSB] : shift_ff[MSB];
            end else if (sub_ff == 2'd1) begin
               scl_in = 1'b1;
            end else begin
               scl_in   = 1'b0;
               shift_in = {shift_ff[MSB-1:0], 1'b0};
            end
         end
         CMD_READ: begin
            priority if (first) begin
               scl_in = 1'b0;
               rx_in  = '0;
            end else if (phase_ff == PHASE_W'(1)) begin
               sda_in = 1'b1;
            end else if (!phase_ff[0]) begin
               scl_in    = 1'b1;
               sample_in = 1'b1;
               rx_in     = {rx_ff[MSB-1:0], shift_ff[MSB]};
               shift_in  = {shift_ff[MSB-1:0], 1'b0};
               out_rx_in = rx_in;
            end else begin
               scl_in    = 1'b0;
               out_rx_in = rx_ff;
            end
         end
         default: begin
         end
      endcase
      if (last_in) begin
         sub_in = 2'd0;
      end
      phase_in = last_in ? '0 : phase_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         sub_ff       <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         sub_ff       <= sub_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         shift_ff      <= shift_in;
         rx_ff         <= rx_in;
         out_scl_ff    <= scl_in;
         out_sda_ff    <= sda_in;
         out_sample_ff <= sample_in;
         out_rx_ff     <= out_rx_in;
         out_last_ff   <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, out_rx_ff, out_sda_ff, out_scl_ff};
   assign rsp_tuser  = out_sample_ff;
   assign rsp_tlast  = out_last_ff;

   `I2CPS_ASSERT(a_phase_in_range, clock, reset,
      !head_valid || phase_ff <= head_entry.last_phase, "phase past end of command")
   `I2CPS_ASSERT(a_busy_has_head, clock, reset,
      first || head_valid, "command left the queue mid-sequence")
   `I2CPS_ASSERT_NEXT(a_last_rewinds, clock, reset, pop, first, "phase not rewound after last")
   `I2CPS_ASSERT(a_sample_scl_high, clock, reset,
      !(rsp_valid_ff && out_sample_ff) || out_scl_ff, "sample taken with SCL low")

endmodule

/* hdl/i2c_master_phase_sequencer.sv */
// Each command takes 2 to 25 pin phases, set by the back-end phase sequencer, which
// emits one phase per cycle while its result is not stalled and starts the next
// command after the last phase. A command transfer is written into the queue, then
// its first phase is registered; a stalled result blocks the sequencer, the queue
// still fills. Reset (synchronous) releases SCL and SDA high and empties the queue.
//------------------------------------------------------------------------------
// I2C master phase sequencer
// Turns I2C master commands into a stream of SCL/SDA pin phases.
//------------------------------------------------------------------------------
module i2c_master_phase_sequencer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // tx_byte, line_bits
   input  logic [2:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // scl_level, sda_level, rx_byte
   output logic        rsp_tuser,   // sample_point
   output logic        rsp_tlast    // last
);
   import i2cps_pkg::*;

   logic    queue_full, push_valid, head_valid, pop;
   cmd_type push_entry, head_entry;

   i2cps_front u_front (
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   i2cps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   i2cps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
